// File: rtl/adcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcu_pkg
// Shared constants, codes and fixed-point helpers for the cell update block.
// ----------------------------------------------------------------------------
package adcu_pkg;

    localparam int MAX_AXES  = 3;
    localparam int FRAC_BITS = 16;
    localparam int NST       = 10;

    localparam logic [1:0] SCH_CENTRAL = 2'd0;
    localparam logic [1:0] SCH_UPWIND1 = 2'd1;
    localparam logic [1:0] SCH_UPWIND3 = 2'd2;

    localparam logic [1:0] STG_EULER = 2'd0;
    localparam logic [1:0] STG_TWO   = 2'd1;
    localparam logic [1:0] STG_THREE = 2'd2;

    localparam logic [2:0] REG_SCHEME = 3'd0;
    localparam logic [2:0] REG_STAGE  = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_ALPHA  = 3'd3;
    localparam logic [2:0] REG_INV_X  = 3'd4;
    localparam logic [2:0] REG_INV_Y  = 3'd5;
    localparam logic [2:0] REG_INV_Z  = 3'd6;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [30:0] INV_ONE = 31'(1 << FRAC_BITS);

    // ceil(2^36 / 3): exact floor division by three for values below 2^35
    localparam logic [34:0] RECIP3 = 35'h555555556;

    typedef struct packed {
        logic               kind;
        logic               av;
        logic               up3;
        logic signed [31:0] c0;
        logic signed [31:0] rhs;
        logic signed [31:0] base;
        logic [30:0]        inv;
        logic signed [33:0] lap;
        logic               flag;
    } carry_t;

    // shift right by s, round to nearest, ties away from zero
    function automatic logic signed [71:0] rnd(input logic signed [71:0] p,
                                               input int unsigned s);
        logic [71:0] m;
        logic [71:0] r;
        m = p[71] ? 72'(-p) : 72'(p);
        r = (m >> s) + ((m >> (s - 1)) & 72'd1);
        return p[71] ? -$signed(r) : $signed(r);
    endfunction

    // {flag, value}
    function automatic logic [32:0] sat32(input logic signed [71:0] x);
        logic [32:0] r;
        if (x > 72'sd2147483647)
            r = {1'b1, 32'h7FFFFFFF};
        else if (x < -72'sd2147483648)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, x[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/advection_diffusion_cell_update.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle; each stage holds its beat only while the
// stage after it is full and stalled.
// Reset: clears all stage valid bits and sets the configuration registers to
// their defaults (inverse spacings to 1.0, everything else to zero).
// ----------------------------------------------------------------------------
// advection_diffusion_cell_update
// Ten-stage pipeline forming upwind/central face fluxes, central diffusion,
// the running right-hand side and an SSP-RK3 stage combination in Q16.16.
// ----------------------------------------------------------------------------
module advection_diffusion_cell_update (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [1:0]         axis,
    input  wire logic signed [31:0] cell_m2,
    input  wire logic signed [31:0] cell_m1,
    input  wire logic signed [31:0] cell_0,
    input  wire logic signed [31:0] cell_p1,
    input  wire logic signed [31:0] cell_p2,
    input  wire logic signed [31:0] face_vel_lo,
    input  wire logic signed [31:0] face_vel_hi,
    input  wire logic signed [31:0] rhs_acc,
    input  wire logic signed [31:0] base_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      result_value,
    output logic                    saturated
);
    import adcu_pkg::*;

    logic [1:0]  scheme_reg;
    logic [1:0]  stage_reg;
    logic [30:0] step_reg;
    logic [30:0] alpha_reg;
    logic [30:0] inv_x_reg;
    logic [30:0] inv_y_reg;
    logic [30:0] inv_z_reg;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;
    carry_t         carry_reg [NST];

    // stage datapath registers
    logic signed [35:0] op_lo_reg, op_hi_reg;
    logic signed [31:0] vlo_reg, vhi_reg;
    logic [1:0]         cen_reg;
    logic [61:0]        pinv_reg;
    logic signed [67:0] pflo_reg, pfhi_reg;
    logic [30:0]        inv2_reg;
    logic signed [32:0] diff_reg;
    logic [61:0]        pk_reg;
    logic signed [64:0] padv_reg;
    logic [30:0]        k_reg;
    logic signed [31:0] adv_reg;
    logic signed [65:0] pdif_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] pe_reg;
    logic signed [34:0] s1v_reg, s2v_reg;
    logic signed [33:0] r1_reg;
    logic [51:0]        pl_reg, ph_reg;
    logic               neg_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] e8_reg;

    // combinational next values
    logic [1:0]         sch;
    logic               av_next;
    logic [30:0]        inv_next;
    logic signed [35:0] op_lo_next, op_hi_next;
    logic [32:0]        inv2_next, flo_next, fhi_next, k_next, adv_next;
    logic [32:0]        dif_next, acc_next, e_next, res_next;
    logic signed [71:0] dif_val;
    logic signed [71:0] e_sum;
    logic [33:0]        m_next;
    logic [68:0]        qsum;
    logic signed [33:0] q_next;
    carry_t             c_in;

    function automatic logic signed [35:0] face_op(
        input logic signed [31:0] v,
        input logic signed [31:0] ll,
        input logic signed [31:0] l,
        input logic signed [31:0] r,
        input logic signed [31:0] rr,
        input logic [1:0]         s
    );
        logic signed [35:0] x;
        logic signed [71:0] t;
        logic signed [35:0] o;
        if (v > 32'sd0)
            x = (36'(r) <<< 1) + 36'(r) + (36'(l) <<< 2) + (36'(l) <<< 1) - 36'(ll);
        else
            x = (36'(l) <<< 1) + 36'(l) + (36'(r) <<< 2) + (36'(r) <<< 1) - 36'(rr);
        t = rnd(72'(x), 3);
        case (s)
            SCH_UPWIND1: o = (v >= 32'sd0) ? 36'(l) : 36'(r);
            SCH_UPWIND3: o = t[35:0];
            default:     o = 36'(l) + 36'(r);
        endcase
        return o;
    endfunction

    function automatic carry_t add_flag(input carry_t c, input logic f);
        carry_t r;
        r = c;
        r.flag = c.flag | f;
        return r;
    endfunction

    // kind 0 result rides in the rhs slot from stage 6 on
    function automatic carry_t put_rhs(input carry_t c, input logic signed [31:0] v);
        carry_t r;
        r = c;
        r.rhs = v;
        return r;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg <= SCH_CENTRAL;
            stage_reg  <= STG_EULER;
            step_reg   <= '0;
            alpha_reg  <= '0;
            inv_x_reg  <= INV_ONE;
            inv_y_reg  <= INV_ONE;
            inv_z_reg  <= INV_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCHEME: scheme_reg <= cfg_data[1:0];
                REG_STAGE:  stage_reg  <= cfg_data[1:0];
                REG_STEP:   step_reg   <= cfg_data;
                REG_ALPHA:  alpha_reg  <= cfg_data;
                REG_INV_X:  inv_x_reg  <= cfg_data;
                REG_INV_Y:  inv_y_reg  <= cfg_data;
                REG_INV_Z:  inv_z_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // stage enables
    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 0 inputs
    always_comb
    begin
        sch     = (scheme_reg == 2'd3) ? SCH_CENTRAL : scheme_reg;
        av_next = (axis != 2'd3) && (32'(axis) < MAX_AXES);
        case (axis)
            AXIS_X:  inv_next = inv_x_reg;
            AXIS_Y:  inv_next = inv_y_reg;
            default: inv_next = inv_z_reg;
        endcase
        op_lo_next = face_op(face_vel_lo, cell_m2, cell_m1, cell_0, cell_p1, sch);
        op_hi_next = face_op(face_vel_hi, cell_m1, cell_0, cell_p1, cell_p2, sch);
        c_in.kind = kind;
        c_in.av   = av_next;
        c_in.up3  = (sch == SCH_UPWIND3);
        c_in.c0   = cell_0;
        c_in.rhs  = rhs_acc;
        c_in.base = base_value;
        c_in.inv  = inv_next;
        c_in.lap  = 34'(cell_m1) - (34'(cell_0) <<< 1) + 34'(cell_p1);
        c_in.flag = 1'b0;
    end

    // per-stage arithmetic
    always_comb
    begin
        inv2_next = sat32(rnd(72'(pinv_reg), FRAC_BITS));
        flo_next  = sat32(rnd(72'(pflo_reg), (cen_reg == 2'd2) ? FRAC_BITS + 1 : FRAC_BITS));
        fhi_next  = sat32(rnd(72'(pfhi_reg), (cen_reg == 2'd2) ? FRAC_BITS + 1 : FRAC_BITS));
        k_next    = sat32(rnd(72'(pk_reg), FRAC_BITS));
        adv_next  = sat32(rnd(72'(padv_reg), FRAC_BITS));
        dif_next  = carry_reg[4].up3 ? 33'd0 : sat32(rnd(72'(pdif_reg), FRAC_BITS));
        dif_val   = 72'($signed(dif_next[31:0]));
        acc_next  = sat32(72'(carry_reg[4].rhs) + 72'(adv_reg) + dif_val);
        e_sum     = 72'(carry_reg[6].c0) + rnd(72'(pe_reg), FRAC_BITS);
        e_next    = sat32(e_sum);
        m_next    = 34'(s2v_reg[34] ? -s2v_reg : s2v_reg) + 34'd1;
        qsum      = (69'(ph_reg) << 17) + 69'(pl_reg);
        q_next    = neg_reg ? -$signed(34'(qsum >> 36)) : $signed(34'(qsum >> 36));
        case (stage_reg)
            STG_TWO:   res_next = sat32(72'(r1_reg));
            STG_THREE: res_next = sat32(72'(q_next));
            default:   res_next = {1'b0, e8_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            carry_reg[0] <= c_in;
            op_lo_reg    <= op_lo_next;
            op_hi_reg    <= op_hi_next;
            vlo_reg      <= face_vel_lo;
            vhi_reg      <= face_vel_hi;
            cen_reg      <= (sch == SCH_CENTRAL) ? 2'd2 : 2'd1;
            pinv_reg     <= inv_next * inv_next;
        end
        if (en[1])
        begin
            carry_reg[1] <= add_flag(carry_reg[0],
                                     inv2_next[32] & carry_reg[0].av & !carry_reg[0].up3);
            pflo_reg     <= vlo_reg * op_lo_reg;
            pfhi_reg     <= vhi_reg * op_hi_reg;
            inv2_reg     <= inv2_next[30:0];
        end
        if (en[2])
        begin
            carry_reg[2] <= add_flag(carry_reg[1],
                                     (flo_next[32] | fhi_next[32]) & carry_reg[1].av);
            diff_reg     <= 33'($signed(flo_next[31:0])) - 33'($signed(fhi_next[31:0]));
            pk_reg       <= alpha_reg * inv2_reg;
        end
        if (en[3])
        begin
            carry_reg[3] <= add_flag(carry_reg[2],
                                     k_next[32] & carry_reg[2].av & !carry_reg[2].up3);
            padv_reg     <= diff_reg * $signed({1'b0, carry_reg[2].inv});
            k_reg        <= k_next[30:0];
        end
        if (en[4])
        begin
            carry_reg[4] <= add_flag(carry_reg[3], adv_next[32] & carry_reg[3].av);
            adv_reg      <= adv_next[31:0];
            pdif_reg     <= carry_reg[3].lap * $signed({1'b0, k_reg});
        end
        if (en[5])
        begin
            carry_reg[5] <= add_flag(carry_reg[4],
                                     (dif_next[32] | acc_next[32]) & carry_reg[4].av);
            acc_reg      <= carry_reg[4].av ? $signed(acc_next[31:0]) : carry_reg[4].rhs;
        end
        if (en[6])
        begin
            carry_reg[6] <= put_rhs(carry_reg[5], acc_reg);
            pe_reg       <= $signed({1'b0, step_reg}) * acc_reg;
        end
        if (en[7])
        begin
            carry_reg[7] <= add_flag(carry_reg[6], e_next[32] & carry_reg[6].kind);
            e_reg        <= e_next[31:0];
            s1v_reg      <= (35'(carry_reg[6].base) <<< 1) + 35'(carry_reg[6].base)
                            + 35'($signed(e_next[31:0]));
            s2v_reg      <= 35'(carry_reg[6].base) + (35'($signed(e_next[31:0])) <<< 1);
        end
        if (en[8])
        begin
            carry_reg[8] <= carry_reg[7];
            r1_reg       <= 34'(rnd(72'(s1v_reg), 2));
            pl_reg       <= 52'(m_next[16:0]) * 52'(RECIP3);
            ph_reg       <= 52'(m_next[33:17]) * 52'(RECIP3);
            neg_reg      <= s2v_reg[34];
            e8_reg       <= e_reg;
        end
        if (en[9])
        begin
            carry_reg[9] <= add_flag(carry_reg[8], res_next[32] & carry_reg[8].kind);
            result_value <= carry_reg[8].kind ? $signed(res_next[31:0]) : carry_reg[8].rhs;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign saturated = carry_reg[NST-1].flag;

endmodule
`default_nettype wire

// File: bench/tb_advection_diffusion_cell_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_advection_diffusion_cell_update
// Self-checking bench for the cell update pipeline. A directed table covers
// reset defaults, field extremes, every scheme, stage and axis. Random phases
// follow, each under new register settings. Every result beat is checked
// against a table or Q16.16 predictor. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_advection_diffusion_cell_update;
    import adcu_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic               kind;
        logic [1:0]         axis;
        logic signed [31:0] m2, m1, c0, p1, p2, vlo, vhi, rhs, base;
    } cell_item_t;

    typedef struct {
        logic [1:0]  scheme;
        logic [1:0]  stage;
        logic [30:0] dt, alpha, ix, iy, iz;
    } cfg_t;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } update_t;

    typedef struct {
        bit         newcfg;
        cfg_t       cfg;
        cell_item_t it;
        bit         typed;
        update_t    want;
    } row_t;

    localparam int    LIMIT = 3000;
    localparam wide_t Q_MAX = 64'sd2147483647;
    localparam wide_t Q_MIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [1:0] axis = '0;
    logic signed [31:0] cell_m2 = '0, cell_m1 = '0, cell_0 = '0, cell_p1 = '0;
    logic signed [31:0] cell_p2 = '0, face_vel_lo = '0, face_vel_hi = '0;
    logic signed [31:0] rhs_acc = '0, base_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic saturated;

    cfg_t    regs;
    update_t pending_q[$];
    row_t    rows[$];
    int      errors = 0;
    int      checked = 0;
    int      sat_seen = 0;
    int      items_sent = 0;
    int      settings = 0;
    int      idle_cycles = 0;
    bit      burst = 0;
    bit      hold_req = 0;

    always #4 clk = ~clk;

    advection_diffusion_cell_update DUT (.*);

    function automatic wide_t round_shift(wide_t x, int s);
        logic [127:0] m, r;
        m = x < 0 ? -x : x;
        r = (m >> s) + ((m >> (s - 1)) & 128'd1);
        return x < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic wide_t clip(wide_t x, inout bit f);
        if (x > Q_MAX) begin
            f = 1;
            return Q_MAX;
        end
        if (x < Q_MIN) begin
            f = 1;
            return Q_MIN;
        end
        return x;
    endfunction

    function automatic wide_t face_flux(wide_t v, wide_t ll, wide_t l, wide_t r,
                                        wide_t rr, logic [1:0] sch, inout bit f);
        wide_t t, p;
        if (sch == SCH_UPWIND1) begin
            p = round_shift(v * (v >= 0 ? l : r), FRAC_BITS);
        end
        else if (sch == SCH_UPWIND3) begin
            t = v > 0 ? round_shift(3 * r + 6 * l - ll, 3)
                      : round_shift(3 * l + 6 * r - rr, 3);
            p = round_shift(v * t, FRAC_BITS);
        end
        else begin
            p = round_shift(v * (l + r), FRAC_BITS + 1);
        end
        return clip(p, f);
    endfunction

    function automatic update_t predict_update(cell_item_t it, cfg_t c);
        update_t u;
        bit f;
        logic [1:0] sch;
        wide_t m2, m1, c0, p1, p2, vlo, vhi, acc, base;
        wide_t inv, flo, fhi, adv, dif, inv2, k, e, res, s, q;
        logic [127:0] mg;
        f = 0;
        m2 = it.m2; m1 = it.m1; c0 = it.c0; p1 = it.p1; p2 = it.p2;
        vlo = it.vlo; vhi = it.vhi; acc = it.rhs; base = it.base;
        sch = c.scheme == 2'd3 ? SCH_CENTRAL : c.scheme;
        if (it.axis < 2'd3 && it.axis < MAX_AXES) begin
            inv = it.axis == AXIS_X ? wide_t'(c.ix)
                : it.axis == AXIS_Y ? wide_t'(c.iy) : wide_t'(c.iz);
            flo = face_flux(vlo, m2, m1, c0, p1, sch, f);
            fhi = face_flux(vhi, m1, c0, p1, p2, sch, f);
            adv = clip(round_shift((flo - fhi) * inv, FRAC_BITS), f);
            dif = 0;
            if (sch != SCH_UPWIND3) begin
                inv2 = clip(round_shift(inv * inv, FRAC_BITS), f);
                k = clip(round_shift(wide_t'(c.alpha) * inv2, FRAC_BITS), f);
                dif = clip(round_shift((m1 - 2 * c0 + p1) * k, FRAC_BITS), f);
            end
            acc = clip(acc + adv + dif, f);
        end
        if (it.kind == 1'b0) begin
            res = acc;
        end
        else begin
            e = clip(c0 + round_shift(wide_t'(c.dt) * acc, FRAC_BITS), f);
            if (c.stage == STG_TWO) begin
                res = round_shift(3 * base + e, 2);
            end
            else if (c.stage == STG_THREE) begin
                s = base + 2 * e;
                mg = s < 0 ? -s : s;
                q = $signed((mg + 1) / 3);
                res = s < 0 ? -q : q;
            end
            else begin
                res = e;
            end
            res = clip(res, f);
        end
        u.value = res[31:0];
        u.sat = f;
        return u;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_regs(cfg_t c);
        logic [30:0] vals[7];
        vals = '{31'(c.scheme), 31'(c.stage), c.dt, c.alpha, c.ix, c.iy, c.iz};
        in_valid = 1'b0;
        wait_drained();
        for (int i = 0; i < 7; i++) begin
            cfg_we = 1'b1;
            cfg_index = 3'(i);
            cfg_data = vals[i];
            @(negedge clk);
        end
        cfg_we = 1'b0;
        regs = c;
        settings++;
    endtask

    task automatic send_item(cell_item_t it, bit typed, update_t want);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = it.kind; axis = it.axis;
        cell_m2 = it.m2; cell_m1 = it.m1; cell_0 = it.c0;
        cell_p1 = it.p1; cell_p2 = it.p2;
        face_vel_lo = it.vlo; face_vel_hi = it.vhi;
        rhs_acc = it.rhs; base_value = it.base;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_q.push_back(typed ? want : predict_update(it, regs));
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value(int mode);
        logic signed [31:0] ext[5];
        ext = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1};
        case (mode)
            0: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            1: return $signed($urandom());
            default: return ext[$urandom_range(0, 4)];
        endcase
    endfunction

    function automatic cell_item_t random_item();
        cell_item_t it;
        int r, mode;
        r = $urandom_range(0, 99);
        mode = r < 80 ? 0 : r < 93 ? 1 : 2;
        it.kind = $urandom_range(0, 1);
        it.axis = $urandom_range(0, 3);
        it.m2 = pick_value(mode); it.m1 = pick_value(mode); it.c0 = pick_value(mode);
        it.p1 = pick_value(mode); it.p2 = pick_value(mode);
        it.vlo = pick_value(mode); it.vhi = pick_value(mode);
        it.rhs = pick_value(mode); it.base = pick_value(mode);
        if ($urandom_range(0, 9) == 0) it.vlo = 0;
        if ($urandom_range(0, 9) == 0) it.vhi = 0;
        return it;
    endfunction

    function automatic cell_item_t flat_item(logic k, logic [1:0] ax,
                                             logic signed [31:0] c0,
                                             logic signed [31:0] rhs);
        cell_item_t it;
        it = '{kind: k, axis: ax, m2: c0, m1: c0, c0: c0, p1: c0, p2: c0,
               vlo: 0, vhi: 0, rhs: rhs, base: 0};
        return it;
    endfunction

    task automatic add_row(bit nc, cfg_t c, cell_item_t it, bit typed,
                           logic signed [31:0] v, logic s);
        row_t r;
        r.newcfg = nc; r.cfg = c; r.it = it; r.typed = typed;
        r.want.value = v; r.want.sat = s;
        rows.push_back(r);
    endtask

    task automatic build_table();
        cfg_t d0, d1, d2, d3, d4;
        cell_item_t it;
        d0 = '{SCH_CENTRAL, STG_EULER, 31'd0, 31'd0, INV_ONE, INV_ONE, INV_ONE};
        d1 = '{SCH_UPWIND1, STG_TWO, 31'h10000, 31'h8000, INV_ONE, 31'h20000, 31'h8000};
        d2 = '{SCH_UPWIND3, STG_THREE, 31'h4000, 31'h10000, 31'h30000, INV_ONE, 31'h20000};
        d3 = '{2'd3, 2'd3, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
               31'h7FFFFFFF};
        d4 = '{SCH_CENTRAL, STG_TWO, 31'h18000, 31'h0, 31'h0, 31'h0, 31'h0};
        add_row(0, d0, flat_item(0, AXIS_X, 32'sd77, 32'sd123), 1, 32'sd123, 0);
        add_row(0, d0, flat_item(0, AXIS_Y, 32'sh7FFFFFFF, 32'sh7FFFFFFF), 1,
                32'sh7FFFFFFF, 0);
        add_row(0, d0, flat_item(0, AXIS_Z, 32'sh80000000, 32'sh80000000), 1,
                32'sh80000000, 0);
        add_row(0, d0, flat_item(1, AXIS_X, 32'sh80000000, 32'sd9), 1,
                32'sh80000000, 0);
        it = random_item();
        it.kind = 0; it.axis = 2'd3; it.rhs = 32'sd5;
        add_row(0, d0, it, 1, 32'sd5, 0);
        add_row(0, d0, random_item(), 0, 0, 0);
        for (int i = 0; i < 4; i++) begin
            it = random_item();
            it.axis = 2'(i);
            it.kind = i[0];
            add_row(i == 0, d1, it, 0, 0, 0);
        end
        for (int i = 0; i < 4; i++) begin
            it = random_item();
            it.axis = 2'(i);
            it.kind = 1;
            it.vlo = i[0] ? -32'sd70000 : 32'sd70000;
            add_row(i == 0, d2, it, 0, 0, 0);
        end
        for (int i = 0; i < 4; i++) begin
            it = flat_item(i[0], 2'(i), i[1] ? 32'sh80000000 : 32'sh7FFFFFFF,
                           i[0] ? 32'sh7FFFFFFF : 32'sh80000000);
            it.m1 = ~it.c0; it.vlo = 32'sh80000000; it.vhi = 32'sh7FFFFFFF;
            it.base = it.rhs;
            add_row(i == 0, d3, it, 0, 0, 0);
        end
        for (int i = 0; i < 3; i++) add_row(i == 0, d4, random_item(), 0, 0, 0);
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (90) @(negedge clk);
                hold_req = 0;
            end
            out_ready = 1'b0;
            repeat (burst ? 0 : $urandom_range(0, 11)) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        update_t w;
        if (rst_n && out_valid && out_ready) begin
            checked++;
            if (saturated) sat_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: result_value=%0d saturated=%0b",
                       result_value, saturated);
                errors++;
            end
            else begin
                w = pending_q.pop_front();
                if (result_value !== w.value) begin
                    $error("result_value: expected %0d, actual %0d", w.value, result_value);
                    errors++;
                end
                if (saturated !== w.sat) begin
                    $error("saturated: expected %0b, actual %0b", w.sat, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        cfg_t c;
        regs = '{SCH_CENTRAL, STG_EULER, 31'd0, 31'd0, INV_ONE, INV_ONE, INV_ONE};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        build_table();
        foreach (rows[i]) begin
            if (rows[i].newcfg) write_regs(rows[i].cfg);
            send_item(rows[i].it, rows[i].typed, rows[i].want);
        end
        for (int ph = 0; ph < 6; ph++) begin
            in_valid = 1'b0;
            c.scheme = 2'(ph);
            c.stage = $urandom_range(0, 3);
            c.dt = ph == 0 ? 31'd0 : ph == 5 ? 31'h7FFFFFFF : 31'($urandom_range(0, 1 << 17));
            c.alpha = ph == 1 ? 31'h7FFFFFFF : 31'($urandom_range(0, 1 << 17));
            c.ix = ph == 2 ? 31'h7FFFFFFF : 31'($urandom_range(0, 4 << 16));
            c.iy = ph == 3 ? 31'd0 : 31'($urandom_range(0, 4 << 16));
            c.iz = 31'($urandom_range(0, 4 << 16));
            write_regs(c);
            burst = ph == 1 || ph == 4;
            for (int n = 0; n < 72; n++) begin
                if (ph == 2 && n == 10) hold_req = 1;
                if (ph == 3 && n == 36) begin
                    in_valid = 1'b0;
                    wait_drained();
                end
                send_item(random_item(), 0, '{0, 0});
            end
        end
        in_valid = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d stencil beats across %0d register settings;", items_sent, settings);
        $display("checked %0d result beats, %0d of them saturated.", checked, sat_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
